// ===== hdl/pdott_pkg.sv =====
// Shared types and constants for the transmit PDO trigger channel.
`default_nettype none
package pdott_pkg;

  localparam logic [3:0] PAYLOAD_MAX_BYTES = 4'd8;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SYNC    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [7:0] TYPE_ACYCLIC    = 8'd0;
  localparam logic [7:0] TYPE_CYCLIC_MAX = 8'd240;
  localparam logic [7:0] TYPE_LAST_SYNC  = 8'd252;

  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_FRAME_ID  = 3'd1;
  localparam logic [2:0] REG_TX_TYPE   = 3'd2;
  localparam logic [2:0] REG_PERIOD    = 3'd3;
  localparam logic [2:0] REG_INHIBIT   = 3'd4;
  localparam logic [2:0] REG_LENGTH    = 3'd5;

  // ceil(x / 10) for x < 2^16: ((x + 9) * 52429) >> 19
  localparam logic [16:0] INHIBIT_ROUND = 17'd9;
  localparam logic [33:0] RECIP_TEN     = 34'd52429;
  localparam int          RECIP_SHIFT   = 19;

  typedef struct packed {
    logic        channel_enabled;
    logic [10:0] frame_id;
    logic [7:0]  transmission_type;
    logic [15:0] event_period_ms;
    logic [15:0] inhibit_time;
    logic [12:0] inhibit_ms;
    logic [3:0]  payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        operational;
    logic [63:0] payload;
    logic        send_accepted;
  } item_t;

  typedef struct packed {
    logic        send_frame;
    logic [10:0] out_id;
    logic [3:0]  out_length;
    logic [63:0] out_data;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/pdott_ifs.sv =====
// Handshake channel interfaces: event input, frame result and register writes.
`default_nettype none
interface pdott_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic        operational;
  logic [63:0] payload;
  logic        send_accepted;
  modport source (output valid, command, now_ms, operational, payload, send_accepted,
                  input ready);
  modport sink (input valid, command, now_ms, operational, payload, send_accepted,
                output ready);
endinterface

interface pdott_out_if;
  logic        valid;
  logic        ready;
  logic        send_frame;
  logic [10:0] out_id;
  logic [3:0]  out_length;
  logic [63:0] out_data;
  modport source (output valid, send_frame, out_id, out_length, out_data, input ready);
  modport sink (input valid, send_frame, out_id, out_length, out_data, output ready);
endinterface

interface pdott_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pdott_cfg.sv =====
// Configuration register bank with the inhibit time pre-scaled to milliseconds.
`default_nettype none
module pdott_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [15:0]  wr_data,
  output pdott_pkg::cfg_t   cfg
);

  logic        channel_enabled;
  logic [10:0] frame_id;
  logic [7:0]  transmission_type;
  logic [15:0] event_period_ms;
  logic [15:0] inhibit_time;
  logic [3:0]  payload_bytes;
  logic [12:0] inhibit_ms;
  logic [33:0] inhibit_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enabled   <= 1'b0;
      frame_id          <= 11'd0;
      transmission_type <= 8'd255;
      event_period_ms   <= 16'd0;
      inhibit_time      <= 16'd0;
      payload_bytes     <= 4'd0;
    end else if (wr_en) begin
      case (wr_index)
        pdott_pkg::REG_ENABLED:  channel_enabled   <= wr_data[0];
        pdott_pkg::REG_FRAME_ID: frame_id          <= wr_data[10:0];
        pdott_pkg::REG_TX_TYPE:  transmission_type <= wr_data[7:0];
        pdott_pkg::REG_PERIOD:   event_period_ms   <= wr_data;
        pdott_pkg::REG_INHIBIT:  inhibit_time      <= wr_data;
        pdott_pkg::REG_LENGTH:   payload_bytes     <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // 100 us units rounded up to ms; registered from the stored inhibit time
  assign inhibit_prod = {17'd0, {1'b0, inhibit_time} + pdott_pkg::INHIBIT_ROUND}
                        * pdott_pkg::RECIP_TEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      inhibit_ms <= 13'd0;
    end else begin
      inhibit_ms <= inhibit_prod[pdott_pkg::RECIP_SHIFT +: 13];
    end
  end

  assign cfg.channel_enabled   = channel_enabled;
  assign cfg.frame_id          = frame_id;
  assign cfg.transmission_type = transmission_type;
  assign cfg.event_period_ms   = event_period_ms;
  assign cfg.inhibit_time      = inhibit_time;
  assign cfg.inhibit_ms        = inhibit_ms;
  assign cfg.payload_bytes     = payload_bytes;

endmodule
`default_nettype wire

// ===== hdl/pdott_core.sv =====
// Trigger decision and channel state: change detection, inhibit, event timer, SYNC count.
`default_nettype none
module pdott_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire pdott_pkg::cfg_t    cfg,
  input  wire pdott_pkg::item_t   item,
  output pdott_pkg::result_t      result
);

  logic [63:0] last_sent_data;
  logic [31:0] last_send_time;
  logic [31:0] inhibit_deadline;
  logic [7:0]  sync_counter;
  logic [7:0]  sync_counter_next;

  logic [3:0]  len;
  logic [63:0] mask;
  logic [63:0] data_m;
  logic        chan_ok;
  logic        changed;
  logic [31:0] elapsed;
  logic [31:0] since_deadline;
  logic        period_due;
  logic        inhibit_ok;
  logic [7:0]  sync_inc;
  logic        offer;
  logic        restart;

  assign len = (cfg.payload_bytes > pdott_pkg::PAYLOAD_MAX_BYTES) ?
               pdott_pkg::PAYLOAD_MAX_BYTES : cfg.payload_bytes;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[8*k +: 8] = (4'(k) < len) ? 8'hFF : 8'h00;
    end
  end

  assign data_m         = item.payload & mask;
  assign chan_ok        = cfg.channel_enabled && (len != 4'd0);
  assign changed        = |((item.payload ^ last_sent_data) & mask);
  assign elapsed        = item.now_ms - last_send_time;
  assign since_deadline = item.now_ms - inhibit_deadline;
  assign period_due     = (cfg.event_period_ms != 16'd0) &&
                          (elapsed >= {16'd0, cfg.event_period_ms});
  assign inhibit_ok     = (cfg.inhibit_time == 16'd0) || !since_deadline[31];
  assign sync_inc       = sync_counter + 8'd1;

  always_comb begin
    offer             = 1'b0;
    restart           = 1'b0;
    sync_counter_next = sync_counter;
    case (item.command)
      pdott_pkg::CMD_RESTART: begin
        restart = 1'b1;
      end
      pdott_pkg::CMD_TICK: begin
        if (item.operational && chan_ok &&
            cfg.transmission_type > pdott_pkg::TYPE_LAST_SYNC) begin
          offer = period_due || (changed && inhibit_ok);
        end
      end
      pdott_pkg::CMD_SYNC: begin
        if (item.operational && chan_ok) begin
          if (cfg.transmission_type == pdott_pkg::TYPE_ACYCLIC) begin
            offer = changed;
          end else if (cfg.transmission_type <= pdott_pkg::TYPE_CYCLIC_MAX) begin
            if (sync_inc >= cfg.transmission_type) begin
              sync_counter_next = 8'd0;
              offer = 1'b1;
            end else begin
              sync_counter_next = sync_inc;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sent_data   <= 64'd0;
      last_send_time   <= 32'd0;
      inhibit_deadline <= 32'd0;
      sync_counter     <= 8'd0;
    end else if (fire) begin
      if (restart) begin
        last_sent_data   <= 64'd0;
        last_send_time   <= item.now_ms;
        inhibit_deadline <= 32'd0;
        sync_counter     <= 8'd0;
      end else begin
        sync_counter <= sync_counter_next;
        if (offer && item.send_accepted) begin
          last_sent_data <= data_m;
          last_send_time <= item.now_ms;
          if (cfg.inhibit_time != 16'd0) begin
            inhibit_deadline <= item.now_ms + {19'd0, cfg.inhibit_ms};
          end
        end
      end
    end
  end

  assign result.send_frame = offer;
  assign result.out_id     = offer ? cfg.frame_id : 11'd0;
  assign result.out_length = offer ? len : 4'd0;
  assign result.out_data   = offer ? data_m : 64'd0;

endmodule
`default_nettype wire

// ===== hdl/pdo_transmit_trigger.sv =====
// Top level of one transmit PDO trigger channel.
// An accepted event beat passes through the input register, then the result register, to its result beat.
// Throughput: one event beat per cycle while the result side does not stall; the state update is the only loop.
// Every event gives exactly one result beat; stalls at the result hold the input stage.
// Reset (rst, synchronous): registers to their defaults, channel state cleared, pipeline empty.
// Register writes are taken every cycle; the inhibit time in ms is registered from the stored inhibit time.
`default_nettype none
module pdo_transmit_trigger (
  input  wire logic   clk,
  input  wire logic   rst,
  pdott_cfg_if.sink   cfg,
  pdott_in_if.sink    evt,
  pdott_out_if.source res
);

  pdott_pkg::cfg_t    cfg_q;
  pdott_pkg::item_t   s1_item;
  pdott_pkg::result_t core_res;
  pdott_pkg::result_t res_q;
  logic               s1_valid;
  logic               res_valid;
  logic               advance;

  assign cfg.ready = 1'b1;

  pdott_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  assign advance   = s1_valid && (!res_valid || res.ready);
  assign evt.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_item.command       <= evt.command;
      s1_item.now_ms        <= evt.now_ms;
      s1_item.operational   <= evt.operational;
      s1_item.payload       <= evt.payload;
      s1_item.send_accepted <= evt.send_accepted;
    end
  end

  pdott_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cfg    (cfg_q),
    .item   (s1_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.send_frame = res_q.send_frame;
  assign res.out_id     = res_q.out_id;
  assign res.out_length = res_q.out_length;
  assign res.out_data   = res_q.out_data;

endmodule
`default_nettype wire

// ===== tb/sv/tb_pdo_transmit_trigger.sv =====
// Self-checking testbench for the transmit PDO trigger channel: directed table, then random phases.
module tb_pdo_transmit_trigger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [31:0] INHIBIT_UNITS_PER_MS = 32'd10;
  localparam int          PHASES = 20;
  localparam int          BEATS_PER_PHASE = 52;

  typedef struct packed {
    logic               is_write;
    logic [2:0]         index;
    logic [15:0]        wdata;
    pdott_pkg::item_t   beat;
    logic               typed;
    pdott_pkg::result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  pdott_cfg_if cfg_ch ();
  pdott_in_if  evt_ch ();
  pdott_out_if res_ch ();

  pdo_transmit_trigger DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .evt (evt_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and channel state
  logic        cfg_en = 1'b0;
  logic [10:0] cfg_id = '0;
  logic [7:0]  cfg_type = 8'd255;
  logic [15:0] cfg_period = '0;
  logic [15:0] cfg_inhibit = '0;
  logic [3:0]  cfg_len = '0;
  logic [63:0] sent_data = '0;
  logic [31:0] sent_time = '0;
  logic [31:0] inhibit_until = '0;
  logic [7:0]  sync_tally = '0;

  pdott_pkg::result_t frames_due[$];
  plan_row_t          plan[$];
  int errors = 0;
  int beats_sent = 0;
  int frames_seen = 0;
  int writes_done = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  function automatic pdott_pkg::result_t predict_frame(input pdott_pkg::item_t it);
    pdott_pkg::result_t r;
    int                 n;
    logic [63:0]        mask;
    logic [31:0]        since;
    logic               changed;
    logic               due;
    r = '0;
    n = (cfg_len > pdott_pkg::PAYLOAD_MAX_BYTES) ? int'(pdott_pkg::PAYLOAD_MAX_BYTES)
                                                 : int'(cfg_len);
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    changed = ((it.payload ^ sent_data) & mask) != '0;
    if (it.command == pdott_pkg::CMD_RESTART) begin
      sent_data = '0;
      inhibit_until = '0;
      sync_tally = '0;
      sent_time = it.now_ms;
      return r;
    end
    if (!it.operational || !cfg_en || n == 0) return r;
    due = 1'b0;
    if (it.command == pdott_pkg::CMD_TICK && cfg_type > pdott_pkg::TYPE_LAST_SYNC) begin
      since = it.now_ms - sent_time;
      due = (cfg_period != '0) && (since >= 32'(cfg_period));
      since = it.now_ms - inhibit_until;
      if (changed && (cfg_inhibit == '0 || !since[31])) due = 1'b1;
    end else if (it.command == pdott_pkg::CMD_SYNC) begin
      if (cfg_type == pdott_pkg::TYPE_ACYCLIC) begin
        due = changed;
      end else if (cfg_type <= pdott_pkg::TYPE_CYCLIC_MAX) begin
        sync_tally = sync_tally + 8'd1;
        if (sync_tally >= cfg_type) begin
          sync_tally = '0;
          due = 1'b1;
        end
      end
    end
    if (due) begin
      r.send_frame = 1'b1;
      r.out_id = cfg_id;
      r.out_length = 4'(n);
      r.out_data = it.payload & mask;
      if (it.send_accepted) begin
        sent_data = r.out_data;
        sent_time = it.now_ms;
        if (cfg_inhibit != '0)
          inhibit_until = it.now_ms +
            (32'(cfg_inhibit) + INHIBIT_UNITS_PER_MS - 32'd1) / INHIBIT_UNITS_PER_MS;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t evt_row(input logic [1:0] cmd, input logic [31:0] t,
                                        input logic op, input logic [63:0] pl,
                                        input logic acc);
    plan_row_t s;
    s = '0;
    s.beat = '{command: cmd, now_ms: t, operational: op, payload: pl, send_accepted: acc};
    return s;
  endfunction

  function automatic plan_row_t pinned(input plan_row_t s, input pdott_pkg::result_t want);
    plan_row_t p;
    p = s;
    p.typed = 1'b1;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t wr_row(input logic [2:0] idx, input logic [15:0] value);
    plan_row_t s;
    s = '0;
    s.is_write = 1'b1;
    s.index = idx;
    s.wdata = value;
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic push_event(input pdott_pkg::item_t it, input logic typed,
                            input pdott_pkg::result_t want);
    int                 gap;
    pdott_pkg::result_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.command <= it.command;
    evt_ch.now_ms <= it.now_ms;
    evt_ch.operational <= it.operational;
    evt_ch.payload <= it.payload;
    evt_ch.send_accepted <= it.send_accepted;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    r = predict_frame(it);
    frames_due.push_back(typed ? want : r);
    beats_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every expected frame is back, then let the pipeline empty
  task automatic settle();
    evt_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      pdott_pkg::REG_ENABLED:  cfg_en = value[0];
      pdott_pkg::REG_FRAME_ID: cfg_id = value[10:0];
      pdott_pkg::REG_TX_TYPE:  cfg_type = value[7:0];
      pdott_pkg::REG_PERIOD:   cfg_period = value;
      pdott_pkg::REG_INHIBIT:  cfg_inhibit = value;
      pdott_pkg::REG_LENGTH:   cfg_len = value[3:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // frame sink with random back-pressure
  initial begin
    int hold;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : frame_check
    pdott_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("result beat with no frame expected");
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (res_ch.send_frame) frames_seen++;
        if (res_ch.send_frame !== want.send_frame) begin
          $error("send_frame mismatch: expected %0h, got %0h", want.send_frame,
                 res_ch.send_frame);
          errors++;
        end
        if (res_ch.out_id !== want.out_id) begin
          $error("out_id mismatch: expected %0h, got %0h", want.out_id, res_ch.out_id);
          errors++;
        end
        if (res_ch.out_length !== want.out_length) begin
          $error("out_length mismatch: expected %0h, got %0h", want.out_length,
                 res_ch.out_length);
          errors++;
        end
        if (res_ch.out_data !== want.out_data) begin
          $error("out_data mismatch: expected %0h, got %0h", want.out_data,
                 res_ch.out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    pdott_pkg::item_t it;
    logic [31:0]      now;
    logic [63:0]      pl;
    logic [15:0]      v;
    logic [7:0]       ty;
    logic [1:0]       cmd;
    int               pick;
    int               n_acyclic;
    int               n_cyclic;
    int               n_reserved;
    int               n_event;

    n_acyclic = 0;
    n_cyclic = 0;
    n_reserved = 0;
    n_event = 0;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    evt_ch.valid = 1'b0;
    evt_ch.command = pdott_pkg::CMD_TICK;
    evt_ch.now_ms = '0;
    evt_ch.operational = 1'b0;
    evt_ch.payload = '0;
    evt_ch.send_accepted = 1'b0;

    // reset defaults: channel disabled, event-driven type
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_TICK, 32'd0, 1'b1, '1, 1'b1), '0));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_SYNC, 32'hFFFF_FFFF, 1'b1, '0, 1'b1), '0));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_RESTART, 32'h8000_0000, 1'b0, '1, 1'b1),
                          '0));
    plan.push_back(pinned(evt_row(CMD_UNUSED, 32'd5, 1'b1, '1, 1'b1), '0));
    plan.push_back(wr_row(REG_SPARE_LO, 16'hFFFF));
    plan.push_back(wr_row(REG_SPARE_HI, 16'hFFFF));
    plan.push_back(wr_row(pdott_pkg::REG_ENABLED, 16'hFFFF));
    plan.push_back(wr_row(pdott_pkg::REG_FRAME_ID, 16'hFFFF));
    plan.push_back(wr_row(pdott_pkg::REG_LENGTH, 16'h000F));
    // length saturates at eight bytes
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_TICK, 32'd100, 1'b1, '1, 1'b1),
                          '{send_frame: 1'b1, out_id: 11'h7FF, out_length: 4'd8,
                            out_data: '1}));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_TICK, 32'd101, 1'b1, '1, 1'b1), '0));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_TICK, 32'd102, 1'b0, '0, 1'b1), '0));
    plan.push_back(pinned(evt_row(CMD_UNUSED, 32'd103, 1'b1, '0, 1'b1), '0));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd104, 1'b1, '0, 1'b0));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd105, 1'b1, '0, 1'b1));
    plan.push_back(wr_row(pdott_pkg::REG_INHIBIT, 16'hFFFF));
    plan.push_back(wr_row(pdott_pkg::REG_PERIOD, 16'hFFFF));
    // deadline 200 + 6554: one ms short is held off, on the deadline it goes
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd200, 1'b1, 64'd1, 1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd6753, 1'b1, 64'd2, 1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd6754, 1'b1, 64'd2, 1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd72289, 1'b1, 64'd2, 1'b1));
    plan.push_back(wr_row(pdott_pkg::REG_LENGTH, 16'd0));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_TICK, 32'd80000, 1'b1, 64'd3, 1'b1), '0));
    plan.push_back(wr_row(pdott_pkg::REG_LENGTH, 16'd3));
    plan.push_back(wr_row(pdott_pkg::REG_TX_TYPE, 16'(pdott_pkg::TYPE_ACYCLIC)));
    plan.push_back(wr_row(pdott_pkg::REG_FRAME_ID, 16'd0));
    plan.push_back(evt_row(pdott_pkg::CMD_SYNC, 32'd80001, 1'b1, 64'hFFFF_FFFF_FF12_3456,
                           1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_SYNC, 32'd80002, 1'b1, 64'hFFFF_FFFF_FF12_3456,
                           1'b1));
    plan.push_back(pinned(evt_row(pdott_pkg::CMD_RESTART, 32'd90000, 1'b1, '0, 1'b1), '0));
    plan.push_back(wr_row(pdott_pkg::REG_TX_TYPE, 16'd2));
    plan.push_back(evt_row(pdott_pkg::CMD_SYNC, 32'd90001, 1'b1, 64'd1, 1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_SYNC, 32'd90002, 1'b1, 64'd1, 1'b0));
    plan.push_back(wr_row(pdott_pkg::REG_TX_TYPE, 16'd241));
    plan.push_back(evt_row(pdott_pkg::CMD_SYNC, 32'd90003, 1'b1, 64'd5, 1'b1));
    plan.push_back(wr_row(pdott_pkg::REG_TX_TYPE, 16'(pdott_pkg::TYPE_LAST_SYNC)));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd90004, 1'b1, 64'd6, 1'b1));
    plan.push_back(wr_row(pdott_pkg::REG_TX_TYPE, 16'd253));
    plan.push_back(wr_row(pdott_pkg::REG_INHIBIT, 16'd1));
    // deadline wraps through zero
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b1, 64'd7, 1'b1));
    plan.push_back(evt_row(pdott_pkg::CMD_TICK, 32'd0, 1'b1, 64'd8, 1'b1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].index, plan[i].wdata);
      end else begin
        push_event(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    now = 32'd100_000;
    pl = {$urandom, $urandom};
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);

      v = 16'($urandom);
      v[0] = ($urandom_range(0, 9) != 0);
      write_reg(pdott_pkg::REG_ENABLED, v);

      v = 16'($urandom);
      pick = $urandom_range(0, 5);
      if (pick == 0) v[10:0] = '0;
      else if (pick == 1) v[10:0] = '1;
      write_reg(pdott_pkg::REG_FRAME_ID, v);

      pick = $urandom_range(0, 9);
      if (pick == 0) ty = pdott_pkg::TYPE_ACYCLIC;
      else if (pick <= 2) ty = 8'($urandom_range(1, 4));
      else if (pick == 3)
        ty = $urandom_range(0, 1) ? pdott_pkg::TYPE_CYCLIC_MAX : 8'($urandom_range(5, 240));
      else if (pick == 4) ty = 8'($urandom_range(241, 252));
      else ty = 8'($urandom_range(253, 255));
      if (ty == pdott_pkg::TYPE_ACYCLIC) n_acyclic++;
      else if (ty <= pdott_pkg::TYPE_CYCLIC_MAX) n_cyclic++;
      else if (ty <= pdott_pkg::TYPE_LAST_SYNC) n_reserved++;
      else n_event++;
      v = 16'($urandom);
      v[7:0] = ty;
      write_reg(pdott_pkg::REG_TX_TYPE, v);

      pick = $urandom_range(0, 9);
      if (pick <= 2) v = '0;
      else if (pick == 3) v = '1;
      else if (pick == 4) v = 16'($urandom);
      else v = 16'($urandom_range(1, 40));
      write_reg(pdott_pkg::REG_PERIOD, v);

      pick = $urandom_range(0, 9);
      if (pick <= 2) v = '0;
      else if (pick == 3) v = '1;
      else if (pick == 4) v = 16'($urandom);
      else v = 16'($urandom_range(1, 300));
      write_reg(pdott_pkg::REG_INHIBIT, v);

      pick = $urandom_range(0, 9);
      v = 16'($urandom);
      if (pick == 0) v[3:0] = '0;
      else if (pick == 1) v[3:0] = 4'($urandom_range(9, 15));
      else if (pick == 2) v[3:0] = 4'd8;
      else v[3:0] = 4'($urandom_range(1, 8));
      write_reg(pdott_pkg::REG_LENGTH, v);

      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));

      pick = $urandom_range(0, 3);
      if (pick == 0) now = $urandom;
      else if (pick == 1) now = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));

      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) now = $urandom;
        else if (pick <= 4) now = now + 32'($urandom_range(16, 2000));
        else now = now + 32'($urandom_range(0, 15));

        pick = $urandom_range(0, 9);
        if (pick == 0) pl = {$urandom, $urandom};
        else if (pick <= 3) pl[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = pdott_pkg::CMD_RESTART;
        else if (pick < 6) cmd = CMD_UNUSED;
        else if ((cfg_type <= pdott_pkg::TYPE_LAST_SYNC) ? (pick < 76) : (pick < 26))
          cmd = pdott_pkg::CMD_SYNC;
        else cmd = pdott_pkg::CMD_TICK;

        it.command = cmd;
        it.now_ms = now;
        it.operational = ($urandom_range(0, 9) != 0);
        it.payload = pl;
        it.send_accepted = ($urandom_range(0, 4) != 0);
        push_event(it, 1'b0, '0);

        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (10) @(negedge clk);
    $display("%0d event beats, %0d frames offered, %0d register writes over %0d phases",
             beats_sent, frames_seen, writes_done, PHASES);
    $display("type settings: %0d acyclic, %0d cyclic, %0d reserved, %0d event driven",
             n_acyclic, n_cyclic, n_reserved, n_event);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
